/* hw/rtl/fast_corner_segment_test_assert.svh */
// assertion macros for the fast corner segment test block
`ifndef FAST_CORNER_SEGMENT_TEST_ASSERT_SVH
`define FAST_CORNER_SEGMENT_TEST_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FCST_ASSERT_SAME(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("fcst same-cycle check failed");
`define FCST_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("fcst next-cycle check failed");
`else
`define FCST_ASSERT_SAME(label, a, b)
`define FCST_ASSERT_NEXT(label, a, b)
`endif
`endif

/* hw/rtl/fcst_pkg.sv */
// shared types and constants for the fast corner segment test
`timescale 1ns / 1ps
`default_nettype none
package fcst_pkg;
  localparam int CIRCLE = 16;
  localparam int WIN = 7;
  localparam int LINES = 6;
  localparam int QDEPTH = 8;
  localparam int QAW = 3;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_ARC_LENGTH = 3'd1;
  localparam logic [2:0] REG_IMAGE_WIDTH = 3'd2;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd3;

  // circle positions in window coordinates, clockwise from the top
  localparam int CIRC_ROW [CIRCLE] = '{0, 0, 1, 2, 3, 4, 5, 6, 6, 6, 5, 4, 3, 2, 1, 0};
  localparam int CIRC_COL [CIRCLE] = '{3, 4, 5, 6, 6, 6, 5, 4, 3, 2, 1, 0, 0, 0, 1, 2};

  typedef struct packed {
    logic [9:0]  col;
    logic [11:0] row;
    logic [15:0] bright;
    logic [15:0] dark;
  } fcst_task_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [3:0] count;
  } fcst_qstat_t;
endpackage
`default_nettype wire

/* hw/rtl/fcst_front.sv */
// front end: position counters, line store, 7x7 window and pixel classification
`timescale 1ns / 1ps
`default_nettype none
module fcst_front import fcst_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  pixel,
  input  wire logic        frame_start,
  input  wire logic [7:0]  threshold,
  input  wire logic [10:0] image_width,
  input  wire logic [12:0] image_height,
  input  wire fcst_qstat_t qstat,
  output logic             push,
  output fcst_task_t       push_data
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam logic [12:0] MAXW13 = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH13 = 13'(MAX_HEIGHT);

  logic [CW-1:0] col_r, col_nxt;
  logic [11:0]   row_r, row_nxt;
  logic          accept;
  logic [CW-1:0] cc;
  logic [11:0]   rc;
  logic [12:0]   cc13, rc13, w_eff, h_eff, cc_inc, rc_inc;
  logic          emit;

  logic [8*LINES-1:0] line_mem_r [MAX_WIDTH];
  logic [8*LINES-1:0] rd_r, last_wr_r, old_col, wr_data;
  logic               fwd_r;
  logic               s1_valid_r, s1_emit_r;
  logic [CW-1:0]      s1_col_r;
  logic [7:0]         s1_px_r;
  logic [9:0]         s1_ccol_r;
  logic [11:0]        s1_crow_r;
  logic               s2_valid_r, s2_emit_r;
  logic [9:0]         s2_ccol_r;
  logic [11:0]        s2_crow_r;
  logic [7:0]         column [WIN];
  logic [7:0]         win_r [WIN][WIN];
  logic [3:0]         inflight;
  logic [15:0]        bright, dark;

  assign inflight = 4'(s1_valid_r & s1_emit_r) + 4'(s2_valid_r & s2_emit_r);
  assign in_ready = (qstat.count + inflight) < 4'(QDEPTH);
  assign accept = in_valid & in_ready;

  always_comb begin
    cc = frame_start ? '0 : col_r;
    rc = frame_start ? '0 : row_r;
    cc13 = 13'(cc);
    rc13 = {1'b0, rc};
    w_eff = {2'b00, image_width};
    if (w_eff == 13'd0) begin
      w_eff = 13'd1;
    end else if (w_eff > MAXW13) begin
      w_eff = MAXW13;
    end
    h_eff = image_height;
    if (h_eff == 13'd0) begin
      h_eff = 13'd1;
    end else if (h_eff > MAXH13) begin
      h_eff = MAXH13;
    end
    emit = (cc13 >= 13'd6) && (rc13 >= 13'd6) && (cc13 < w_eff) && (rc13 < h_eff);
    cc_inc = cc13 + 13'd1;
    rc_inc = rc13 + 13'd1;
    if (cc_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (rc_inc >= h_eff) ? 12'd0 : rc_inc[11:0];
    end else begin
      col_nxt = cc_inc[CW-1:0];
      row_nxt = rc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      fwd_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        fwd_r <= s1_valid_r && (s1_col_r == cc);
      end
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
    end
  end

  // line store: read on accept, write back the shifted column in the following cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= line_mem_r[cc];
      s1_col_r <= cc;
      s1_px_r <= pixel;
      s1_emit_r <= emit;
      s1_ccol_r <= 10'(cc13 - 13'd3);
      s1_crow_r <= rc - 12'd3;
    end
    if (s1_valid_r) begin
      line_mem_r[s1_col_r] <= wr_data;
      last_wr_r <= wr_data;
      s2_emit_r <= s1_emit_r;
      s2_ccol_r <= s1_ccol_r;
      s2_crow_r <= s1_crow_r;
    end
  end

  // bypass when the previous request wrote this column in the read cycle
  assign old_col = fwd_r ? last_wr_r : rd_r;

  always_comb begin
    for (int r = 0; r < LINES; r++) begin
      column[r] = old_col[8*r +: 8];
    end
    column[LINES] = s1_px_r;
    for (int r = 0; r < LINES; r++) begin
      wr_data[8*r +: 8] = column[r+1];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      for (int r = 0; r < WIN; r++) begin
        for (int c = 0; c < WIN - 1; c++) begin
          win_r[r][c] <= win_r[r][c+1];
        end
        win_r[r][WIN-1] <= column[r];
      end
    end
  end

  always_comb begin
    logic [9:0] c10, t10, p10;
    c10 = {2'b00, win_r[3][3]};
    t10 = {2'b00, threshold};
    for (int k = 0; k < CIRCLE; k++) begin
      p10 = {2'b00, win_r[CIRC_ROW[k]][CIRC_COL[k]]};
      bright[k] = p10 > (c10 + t10);
      dark[k] = (p10 + t10) < c10;
    end
  end

  assign push = s2_valid_r & s2_emit_r;
  assign push_data = '{col: s2_ccol_r, row: s2_crow_r, bright: bright, dark: dark};
endmodule
`default_nettype wire

/* hw/rtl/fcst_queue.sv */
// short queue between the classifying front and the arc-testing back
`timescale 1ns / 1ps
`default_nettype none
module fcst_queue import fcst_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire fcst_task_t  push_data,
  input  wire logic        pop,
  output fcst_task_t       head,
  output fcst_qstat_t      qstat
);
  fcst_task_t     slot_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [3:0]     count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      count_r <= count_r + 4'(push) - 4'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

  assign head = slot_r[rp_r];
  assign qstat = '{full: count_r == 4'(QDEPTH), empty: count_r == 4'd0, count: count_r};
endmodule
`default_nettype wire

/* hw/rtl/fcst_back.sv */
// back end: circular arc test on the classified masks and result register
`timescale 1ns / 1ps
`default_nettype none
module fcst_back import fcst_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [4:0]  arc_length,
  input  wire fcst_task_t  head,
  input  wire fcst_qstat_t qstat,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [9:0]       center_col,
  output logic [11:0]      center_row,
  output logic             is_corner
);
  logic        valid_r;
  logic [9:0]  col_r;
  logic [11:0] row_r;
  logic        corner_r;
  logic        corner;

  function automatic logic [15:0] rotr(input logic [15:0] x, input logic [3:0] s);
    logic [31:0] d;
    d = {x, x} >> s;
    return d[15:0];
  endfunction

  // true when some circular run of ones is at least need long
  function automatic logic has_run(input logic [15:0] m, input logic [4:0] need);
    logic [15:0] p [5];
    logic [15:0] acc;
    logic [4:0]  off;
    p[0] = m;
    for (int i = 1; i < 5; i++) begin
      p[i] = p[i-1] & rotr(p[i-1], 4'(1 << (i - 1)));
    end
    acc = 16'hFFFF;
    off = 5'd0;
    for (int b = 4; b >= 0; b--) begin
      if (need[b]) begin
        acc = acc & rotr(p[b], off[3:0]);
        off = off + 5'(1 << b);
      end
    end
    return |acc;
  endfunction

  always_comb begin
    logic [4:0] need;
    need = (arc_length == 5'd0) ? 5'd1 : arc_length;
    if (need > 5'(CIRCLE)) begin
      corner = 1'b0;
    end else begin
      corner = has_run(head.bright, need) | has_run(head.dark, need);
    end
  end

  assign pop = !qstat.empty && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      col_r <= head.col;
      row_r <= head.row;
      corner_r <= corner;
    end
  end

  assign out_valid = valid_r;
  assign center_col = col_r;
  assign center_row = row_r;
  assign is_corner = corner_r;
endmodule
`default_nettype wire

/* hw/rtl/fast_corner_segment_test.sv */
// an accepted request passes front stages s1 and s2, the queue and the result register before its result shows on out_*
// throughput: one pixel per cycle while in_tready holds, bounded by the line store read-modify-write pipeline
// in_tready drops once queued plus in-flight centers reach the 8-entry queue depth
// reset (rst_n low, synchronous) clears counters, pipeline valids, queue and config to defaults
// line store and window hold undefined data until the first rows of a frame have streamed in
`timescale 1ns / 1ps
`default_nettype none
`include "fast_corner_segment_test_assert.svh"
module fast_corner_segment_test import fcst_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // pixel[7:0]
  input  wire logic        in_tuser,   // frame_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // center_col[9:0], center_row[21:10], zero pad
  output logic             out_tuser,  // is_corner
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);
  // configuration registers
  logic [7:0]  threshold_r;
  logic [4:0]  arc_length_r;
  logic [10:0] image_width_r;
  logic [12:0] image_height_r;

  // front to queue
  logic        push;
  fcst_task_t  push_data;
  // queue to back
  logic        pop;
  fcst_task_t  head;
  fcst_qstat_t qstat;

  logic [9:0]  center_col;
  logic [11:0] center_row;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= 8'd20;
      arc_length_r <= 5'd9;
      image_width_r <= 11'd640;
      image_height_r <= 13'd480;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESHOLD:    threshold_r <= cfg_data[7:0];
        REG_ARC_LENGTH:   arc_length_r <= cfg_data[4:0];
        REG_IMAGE_WIDTH:  image_width_r <= cfg_data[10:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front: position tracking, line store, window, bright and dark masks
  fcst_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .pixel        (in_tdata),
    .frame_start  (in_tuser),
    .threshold    (threshold_r),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .qstat        (qstat),
    .push         (push),
    .push_data    (push_data)
  );

  // decoupling queue, front reserves room before it accepts a pixel
  fcst_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // back: contiguous arc search with wraparound, result register
  fcst_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .arc_length (arc_length_r),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .center_col (center_col),
    .center_row (center_row),
    .is_corner  (out_tuser)
  );

  assign out_tdata = {2'b00, center_row, center_col};

  // the front never pushes into a full queue
  `FCST_ASSERT_SAME(a_no_overflow, push, !qstat.full)
  // the back only pops a queue that holds something
  `FCST_ASSERT_SAME(a_no_underflow, pop, !qstat.empty)
  // a pop always lands in the result register
  `FCST_ASSERT_NEXT(a_pop_shows, pop, out_tvalid)
endmodule
`default_nettype wire

/* dv/tb.sv */
// testbench for the fast corner segment test: streamed frames checked against a built-in predictor
`timescale 1ns / 1ps
module tb;
  import fcst_pkg::*;

  localparam int MAXW = 1024;

  // one center evaluation as the block reports it
  typedef struct {
    bit [9:0]  col;
    bit [11:0] row;
    bit        corner;
  } center_rec_t;

  // directed frame: a 7x7 image whose only center sees the given ring
  typedef struct {
    bit [7:0]  thr;
    bit [4:0]  arc;
    bit [7:0]  center;
    bit [15:0] bright_mask;
    bit [15:0] dark_mask;
    bit [7:0]  bright_val;
    bit [7:0]  dark_val;
    bit        typed;      // expected corner flag typed in below
    bit        corner;
  } ring_case_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // pixel[7:0]
  logic        in_tuser;   // frame_start
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // center_col[9:0], center_row[21:10], zero pad
  logic        out_tuser;  // is_corner
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_data;

  fast_corner_segment_test u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the configuration and state
  bit [7:0]  thr_q;
  bit [4:0]  arc_q;
  bit [10:0] width_q;
  bit [12:0] height_q;
  bit [7:0]  line_mem [LINES*MAXW];
  bit [7:0]  win [WIN][WIN];
  int        col_cnt;
  int        row_cnt;

  center_rec_t centers_due[$];
  int          errors;
  int          burst_left;
  int          hold_cycles;  // long receiver hold-off, counted down by the receiver
  bit          forced_on;    // directed frames push the typed flag instead
  bit          forced_corner;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous fixed limit well above the slowest correct run
  initial begin
    #50ms;
    $display("tb NOT OK");
    $finish;
  end

  function automatic int longest_arc(bit [15:0] mask);
    int best;
    int run;
    best = 0;
    run = 0;
    if (mask == 16'hFFFF) return CIRCLE;
    // walk the ring twice so an arc crossing position 0 is counted whole
    for (int i = 0; i < 2*CIRCLE; i++) begin
      if (mask[i % CIRCLE]) begin
        run++;
        if (run > best) best = run;
      end else begin
        run = 0;
      end
    end
    return best;
  endfunction

  function automatic bit ring_test();
    int cv;
    int t;
    int p;
    int need;
    bit [15:0] bright;
    bit [15:0] dark;
    cv = win[3][3];
    t = thr_q;
    need = (arc_q == 0) ? 1 : arc_q;
    bright = '0;
    dark = '0;
    if (need > CIRCLE) return 1'b0;
    for (int k = 0; k < CIRCLE; k++) begin
      p = win[CIRC_ROW[k]][CIRC_COL[k]];
      if (p > cv + t) bright[k] = 1'b1;
      else if (p < cv - t) dark[k] = 1'b1;
    end
    return (longest_arc(bright) >= need) || (longest_arc(dark) >= need);
  endfunction

  // advance the predictor by one accepted pixel
  function automatic void take_pixel(bit [7:0] px, bit fs);
    int w;
    int h;
    int base;
    bit [7:0] colv [WIN];
    center_rec_t rec;
    w = (width_q < 1) ? 1 : (width_q > MAXW) ? MAXW : width_q;
    h = (height_q < 1) ? 1 : (height_q > MAX_HEIGHT) ? MAX_HEIGHT : height_q;
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    base = (col_cnt % MAXW) * LINES;
    for (int r = 0; r < LINES; r++) colv[r] = line_mem[base + r];
    colv[LINES] = px;
    for (int r = 0; r < LINES; r++) line_mem[base + r] = colv[r + 1];
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < WIN - 1; c++) win[r][c] = win[r][c + 1];
      win[r][WIN - 1] = colv[r];
    end
    if (col_cnt >= 6 && row_cnt >= 6 && col_cnt < w && row_cnt < h) begin
      rec.col = 10'(col_cnt - 3);
      rec.row = 12'(row_cnt - 3);
      rec.corner = forced_on ? forced_corner : ring_test();
      centers_due.insert(centers_due.size(), rec);
    end
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= h) row_cnt = 0;
    end
  endfunction

  // one pixel request, with bursts and random gaps on the sending side
  task automatic send_pixel(input bit [7:0] px, input bit fs);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = px;
    in_tuser = fs;
    do @(posedge clk); while (!in_tready);
    take_pixel(px, fs);
    burst_left--;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // wait for every expected center, then let the pipeline empty out
  task automatic drain();
    stop_sending();
    while (centers_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val[12:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_THRESHOLD:    thr_q = val[7:0];
      REG_ARC_LENGTH:   arc_q = val[4:0];
      REG_IMAGE_WIDTH:  width_q = val[10:0];
      REG_IMAGE_HEIGHT: height_q = val[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_frame(input int thr, input int arc, input int w, input int h);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_ARC_LENGTH, arc);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  // textured frame: blocks of dark and bright with some pure noise so corners show up
  task automatic stream_frame(input int w, input int h, input int rows);
    bit [7:0] px;
    bit fs;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < w; c++) begin
        if ($urandom_range(0, 3) == 0) px = 8'($urandom);
        else if (((c / 3) + (r / 2)) % 2 == 1) px = 8'(180 + $urandom_range(0, 75));
        else px = 8'($urandom_range(0, 70));
        fs = (r == 0 && c == 0);
        // rare restart in mid-frame
        if (!fs && $urandom_range(0, 999) == 0) fs = 1'b1;
        send_pixel(px, fs);
      end
    end
  endtask

  // receiver: changing stall patterns plus the long hold-off on request
  initial begin
    int mode;
    int left;
    int phase;
    out_tready = 1'b0;
    mode = 0;
    left = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 300);
      end
      left--;
      phase++;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready = 1'b0;
      end else begin
        case (mode)
          0: out_tready = 1'b1;
          1: out_tready = 1'($urandom_range(0, 1));
          2: out_tready = (phase % 4) != 0;
          default: out_tready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // result checker against the oldest expected center
  always @(posedge clk) begin
    center_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (centers_due.size() == 0) begin
        $error("unexpected result col=%0d row=%0d corner=%0d",
               out_tdata[9:0], out_tdata[21:10], out_tuser);
        errors++;
      end else begin
        want = centers_due.pop_front();
        if (out_tdata[9:0] !== want.col) begin
          $error("center_col expected %0d actual %0d", want.col, out_tdata[9:0]);
          errors++;
        end
        if (out_tdata[21:10] !== want.row) begin
          $error("center_row expected %0d actual %0d", want.row, out_tdata[21:10]);
          errors++;
        end
        if (out_tuser !== want.corner) begin
          $error("is_corner expected %0d actual %0d", want.corner, out_tuser);
          errors++;
        end
      end
    end
  end

  // directed rings; typed flags only where the answer is plain
  ring_case_t ring_cases [] = '{
    '{8'd20,  5'd9,  8'd100, 16'h01FF, 16'h0000, 8'd121, 8'd0,  1'b1, 1'b1},  // arc of 9 bright
    '{8'd20,  5'd9,  8'd100, 16'h01FF, 16'h0000, 8'd120, 8'd0,  1'b1, 1'b0},  // equal is not brighter
    '{8'd20,  5'd8,  8'd100, 16'hF00F, 16'h0000, 8'd200, 8'd0,  1'b1, 1'b1},  // arc wraps past top
    '{8'd20,  5'd9,  8'd100, 16'hF00F, 16'h0000, 8'd200, 8'd0,  1'b1, 1'b0},  // wrapped arc too short
    '{8'd20,  5'd12, 8'd100, 16'h0000, 16'h0FFF, 8'd0,   8'd79, 1'b1, 1'b1},  // dark arc
    '{8'd0,   5'd16, 8'd255, 16'hFFFF, 16'h0000, 8'd255, 8'd0,  1'b1, 1'b0},  // flat white
    '{8'd255, 5'd1,  8'd0,   16'hFFFF, 16'h0000, 8'd255, 8'd0,  1'b1, 1'b0},  // widest margin
    '{8'd0,   5'd0,  8'd50,  16'h0001, 16'h0000, 8'd51,  8'd0,  1'b1, 1'b1},  // zero arc acts as one
    '{8'd10,  5'd16, 8'd100, 16'hFFFF, 16'h0000, 8'd200, 8'd0,  1'b1, 1'b1},  // full ring
    '{8'd10,  5'd17, 8'd100, 16'hFFFF, 16'h0000, 8'd200, 8'd0,  1'b1, 1'b0},  // arc above ring size
    '{8'd10,  5'd31, 8'd0,   16'h0000, 16'h0000, 8'd0,   8'd0,  1'b1, 1'b0},  // arc field maxed
    '{8'd0,   5'd1,  8'd128, 16'h5555, 16'hAAAA, 8'd255, 8'd0,  1'b0, 1'b0},  // alternating ring
    '{8'd30,  5'd5,  8'd90,  16'h00F8, 16'h3E00, 8'd140, 8'd40, 1'b0, 1'b0}   // mixed arcs
  };

  initial begin
    ring_case_t rc;
    bit [7:0] px;
    int w;
    int h;
    int k;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    burst_left = 0;
    hold_cycles = 0;
    forced_on = 1'b0;
    forced_corner = 1'b0;
    thr_q = 8'd20;
    arc_q = 5'd9;
    width_q = 11'd640;
    height_q = 13'd480;
    col_cnt = 0;
    row_cnt = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part: one 7x7 frame per ring case
    write_reg(REG_IMAGE_WIDTH, 7);
    write_reg(REG_IMAGE_HEIGHT, 7);
    foreach (ring_cases[i]) begin
      rc = ring_cases[i];
      write_reg(REG_THRESHOLD, rc.thr);
      write_reg(REG_ARC_LENGTH, rc.arc);
      forced_on = rc.typed;
      forced_corner = rc.corner;
      for (int r = 0; r < WIN; r++) begin
        for (int c = 0; c < WIN; c++) begin
          px = rc.center;
          for (k = 0; k < CIRCLE; k++) begin
            if (CIRC_ROW[k] == r && CIRC_COL[k] == c) begin
              if (rc.bright_mask[k]) px = rc.bright_val;
              else if (rc.dark_mask[k]) px = rc.dark_val;
            end
          end
          send_pixel(px, r == 0 && c == 0);
        end
      end
      drain();
      forced_on = 1'b0;
    end

    // clamped and degenerate sizes
    set_frame(15, 3, 16, 8191);
    stream_frame(16, 4096, 8);
    drain();
    set_frame(0, 1, 0, 0);
    stream_frame(1, 1, 20);
    drain();
    set_frame(20, 9, 5, 3);
    stream_frame(5, 3, 8);
    drain();

    // random phases with small frames; pressure phases mixed in
    for (int ph = 0; ph < 9; ph++) begin
      w = $urandom_range(7, 16);
      h = $urandom_range(7, 9);
      k = $urandom_range(0, 9);
      set_frame($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(5, 60),
                k == 0 ? $urandom_range(0, 31) : $urandom_range(1, 16),
                w, h);
      if (ph % 8 == 3) hold_cycles = 400;  // receiver backs up while pixels keep coming
      for (int f = $urandom_range(1, 2); f > 0; f--) stream_frame(w, h, h);
      if (ph % 8 == 6) begin
        // sender pauses until everything outstanding has come back
        stop_sending();
        while (centers_due.size() != 0) @(posedge clk);
        stream_frame(w, h, h);
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/fcst_pkg.sv
hw/rtl/fcst_front.sv
hw/rtl/fcst_queue.sv
hw/rtl/fcst_back.sv
hw/rtl/fast_corner_segment_test.sv
dv/tb.sv
